[rtl/core/pwcr_pkg.sv]
// shared types and constants of the pulse-width card reader
package pwcr_pkg;

    localparam int FRAME_BITS_DEF = 23;
    localparam int MEMBER_CNT = 6;
    localparam int MEMBER_W = 10;
    localparam int HOLD_W = 8;
    localparam int NUM_W = 11;
    localparam int STAMP_W = 16;
    localparam int COUNT_W = 16;
    localparam int SKIP_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [SKIP_W-1:0] SKIP_AT_RESET = 3'd2;
    localparam logic [SKIP_W-1:0] SKIP_AFTER_CARD = 3'd4;
    localparam logic [HOLD_W-1:0] LED_HOLD_RESET = 8'd15;

    // entry 0 is member_a
    localparam logic [MEMBER_CNT-1:0][MEMBER_W-1:0] MEMBER_RESET =
        {10'd531, 10'd123, 10'd97, 10'd642, 10'd456, 10'd789};

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEMBER_A = 3'd0,
        CFG_MEMBER_B = 3'd1,
        CFG_MEMBER_C = 3'd2,
        CFG_MEMBER_D = 3'd3,
        CFG_MEMBER_E = 3'd4,
        CFG_MEMBER_F = 3'd5,
        CFG_LED_HOLD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] capture_time;
    } t_in_beat;

    typedef struct packed {
        logic               led_lit;
        logic [COUNT_W-1:0] person_count;
        logic               card_done;
        logic               card_accepted;
        logic [NUM_W-1:0]   card_number;
    } t_out_beat;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] number;
    } t_frame_evt;

endpackage

[rtl/core/pwcr_frame.sv]
// edge timing, bit classification and frame assembly
module pwcr_frame import pwcr_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_beat   i_beat,
    output t_frame_evt o_evt
);

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [SKIP_W-1:0]     r_skip, n_skip;
    logic                  r_expect, n_expect;
    logic                  r_first, n_first;
    logic [STAMP_W-1:0]    r_fall, n_fall;
    logic [STAMP_W-1:0]    r_rise, n_rise;
    logic [STAMP_W-1:0]    r_low, n_low;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [FRAME_BITS-1:0] r_bits, n_bits;

    logic [STAMP_W-1:0]    w_high;
    logic [20:0]           w_high21;
    logic [20:0]           w_low10;
    logic                  w_one;
    logic                  w_sync;
    logic [CNT_W-1:0]      w_cnt;
    logic                  w_last;
    logic [FRAME_BITS-1:0] w_bits;
    logic [3:0]            w_d0, w_d1, w_d2;
    logic [NUM_W-1:0]      w_num;
    logic                  w_done;

    assign w_high   = i_beat.capture_time - r_rise;
    assign w_high21 = 21'(w_high) * 21'd21;
    assign w_low10  = 21'(r_low) * 21'd10;
    assign w_one    = w_high21 > w_low10;
    assign w_sync   = !w_one && ({3'b000, r_low} > {w_high, 3'b000});
    assign w_cnt    = w_sync ? CNT_W'(1) : CNT_W'(r_idx) + CNT_W'(1);
    assign w_last   = w_cnt >= CNT_W'(FRAME_BITS);

    always_comb begin
        w_bits = r_bits;
        if (!w_sync) begin
            w_bits[r_idx] = w_one;
        end
    end

    assign w_d0  = {w_bits[8], w_bits[9], w_bits[10], w_bits[11]};
    assign w_d1  = {w_bits[12], w_bits[13], w_bits[14], w_bits[15]};
    assign w_d2  = {w_bits[16], w_bits[17], w_bits[18], w_bits[19]};
    assign w_num = NUM_W'(w_d0) * NUM_W'(100) + NUM_W'(w_d1) * NUM_W'(10) + NUM_W'(w_d2);

    always_comb begin
        n_skip   = r_skip;
        n_expect = r_expect;
        n_first  = r_first;
        n_fall   = r_fall;
        n_rise   = r_rise;
        n_low    = r_low;
        n_idx    = r_idx;
        n_bits   = r_bits;
        w_done   = 1'b0;
        if (i_step && i_beat.action == ACT_EDGE) begin
            if (r_skip != '0) begin
                n_skip = r_skip - SKIP_W'(1);
            end else if (r_expect) begin
                n_rise   = i_beat.capture_time;
                n_expect = 1'b0;
                n_first  = 1'b0;
                n_low    = i_beat.capture_time - r_fall;
            end else begin
                n_fall   = i_beat.capture_time;
                n_expect = 1'b1;
                if (!r_first) begin
                    n_bits = w_bits;
                    if (w_last) begin
                        w_done  = 1'b1;
                        n_first = 1'b1;
                        n_idx   = '0;
                        n_skip  = SKIP_AFTER_CARD;
                    end else begin
                        n_idx = IDX_W'(w_cnt);
                    end
                end
            end
        end
    end

    assign o_evt.done   = w_done;
    assign o_evt.number = w_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip   <= SKIP_AT_RESET;
            r_expect <= 1'b0;
            r_first  <= 1'b1;
            r_fall   <= '0;
            r_rise   <= '0;
            r_low    <= '0;
            r_idx    <= '0;
        end else begin
            r_skip   <= n_skip;
            r_expect <= n_expect;
            r_first  <= n_first;
            r_fall   <= n_fall;
            r_rise   <= n_rise;
            r_low    <= n_low;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

endmodule

[rtl/core/pwcr_access.sv]
// member registers, card match, led hold timer and person count
module pwcr_access import pwcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  logic                  i_tick,
    input  t_frame_evt            i_evt,
    output logic                  o_led,
    output logic [COUNT_W-1:0]    o_count,
    output logic [NUM_W-1:0]      o_number,
    output logic                  o_match
);

    logic [MEMBER_W-1:0] r_member [MEMBER_CNT];
    logic [HOLD_W-1:0]   r_hold_cfg;

    logic                r_led, n_led;
    logic [HOLD_W-1:0]   r_hold, n_hold;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [NUM_W-1:0]    r_number, n_number;

    logic [HOLD_W-1:0]   w_hold_dec;
    logic                w_match;

    always_comb begin
        w_match = 1'b0;
        for (int i = 0; i < MEMBER_CNT; i++) begin
            if ({1'b0, r_member[i]} == i_evt.number) begin
                w_match = 1'b1;
            end
        end
    end

    assign w_hold_dec = r_hold - HOLD_W'(1);

    always_comb begin
        n_led    = r_led;
        n_hold   = r_hold;
        n_count  = r_count;
        n_number = r_number;
        if (i_step) begin
            if (i_tick) begin
                if (r_led) begin
                    if (w_hold_dec == '0) begin
                        n_led  = 1'b0;
                        n_hold = r_hold_cfg;
                    end else begin
                        n_hold = w_hold_dec;
                    end
                end
            end else if (i_evt.done) begin
                n_number = i_evt.number;
                if (w_match) begin
                    n_led   = 1'b1;
                    n_count = r_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led    <= 1'b0;
            r_hold   <= LED_HOLD_RESET;
            r_count  <= '0;
            r_number <= '0;
        end else begin
            r_led    <= n_led;
            r_hold   <= n_hold;
            r_count  <= n_count;
            r_number <= n_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEMBER_CNT; i++) begin
                r_member[i] <= MEMBER_RESET[i];
            end
            r_hold_cfg <= LED_HOLD_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MEMBER_A: r_member[0] <= i_cfg_data;
                CFG_MEMBER_B: r_member[1] <= i_cfg_data;
                CFG_MEMBER_C: r_member[2] <= i_cfg_data;
                CFG_MEMBER_D: r_member[3] <= i_cfg_data;
                CFG_MEMBER_E: r_member[4] <= i_cfg_data;
                CFG_MEMBER_F: r_member[5] <= i_cfg_data;
                CFG_LED_HOLD: r_hold_cfg  <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_led    = r_led;
    assign o_count  = r_count;
    assign o_number = r_number;
    assign o_match  = w_match;

endmodule

[rtl/core/pulse_width_card_reader_unit.sv]
// top level of the pulse-width card reader
// Each input beat is either a capture edge with a 16-bit timer stamp or a timer tick, and
// each produces exactly one output beat. A beat is held in the input register and
// is then decoded into the result register; a new beat is
// taken every cycle as long as results are drained; the frame decode, six member compares
// and hold counter all settle in that single stage. Configuration writes are taken every
// cycle and should only be issued while no beat is in flight.
module pulse_width_card_reader_unit import pwcr_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic         r_in_vld;
    t_in_beat     r_in;
    logic         r_out_vld;
    logic         r_done;
    logic         r_acc;

    logic         w_adv;
    logic         w_tick;
    t_frame_evt   w_evt;
    logic         w_led;
    logic [COUNT_W-1:0] w_count;
    logic [NUM_W-1:0]   w_number;
    logic         w_match;

    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_tick      = r_in.action == ACT_TICK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_done <= w_evt.done;
            r_acc  <= w_evt.done && w_match;
        end
    end

    pwcr_frame #(
        .FRAME_BITS(FRAME_BITS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_beat  (r_in),
        .o_evt   (w_evt)
    );

    pwcr_access u_access (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_adv),
        .i_tick      (w_tick),
        .i_evt       (w_evt),
        .o_led       (w_led),
        .o_count     (w_count),
        .o_number    (w_number),
        .o_match     (w_match)
    );

    assign o_out_valid              = r_out_vld;
    assign o_out_data.led_lit       = w_led;
    assign o_out_data.person_count  = w_count;
    assign o_out_data.card_done     = r_done;
    assign o_out_data.card_accepted = r_acc;
    assign o_out_data.card_number   = w_number;

`ifndef SYNTH
    a_acc_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_acc |-> r_done && w_led)
        else $error("accepted card without frame end or led");

    a_tick_no_card: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_tick |=> !r_done)
        else $error("tick completed a card");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> w_count == $past(w_count) + COUNT_W'(r_acc))
        else $error("person count out of step with accepted cards");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_count) && $stable(w_number))
        else $error("result state moved without a beat");
`endif

endmodule

[bench/tb_pulse_width_card_reader_unit.sv]
// testbench for the pulse-width card reader: random and directed beats vs. predictor or fixed results
module tb_pulse_width_card_reader_unit;
    import pwcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_BEATS = 260;
    localparam int LAST_PHASE = 4;
    localparam int ZERO_HOLD_PHASE = 3;
    localparam int TICK_BURST = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam t_out_beat QUIET_RESULT = '0;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [21] = '{
        '{'{ACT_TICK, 16'h0000}, 1'b1, QUIET_RESULT},
        '{'{ACT_EDGE, 16'hFFFF}, 1'b1, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0000}, 1'b1, QUIET_RESULT},
        '{'{ACT_EDGE, 16'hFFF0}, 1'b1, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0010}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0014}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0029}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0033}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0133}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0134}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0135}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0134}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0133}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h2132}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h2131}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h4131}, 1'b0, QUIET_RESULT},
        '{'{ACT_TICK, 16'hFFFF}, 1'b1, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h4131}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h4131}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'hFFFF}, 1'b0, QUIET_RESULT},
        '{'{ACT_EDGE, 16'h0000}, 1'b0, QUIET_RESULT}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [SKIP_W-1:0]   skip_left;
    logic                want_rise;
    logic                stamp_only;
    logic [STAMP_W-1:0]  fall_ts;
    logic [STAMP_W-1:0]  rise_ts;
    logic [STAMP_W-1:0]  low_span;
    logic [4:0]          bit_idx;
    logic                frame_store [32];
    logic                led_on;
    logic [HOLD_W-1:0]   hold_left;
    logic [COUNT_W-1:0]  cards_ok;
    logic [NUM_W-1:0]    last_card;
    logic [MEMBER_W-1:0] member_no [MEMBER_CNT];
    logic [HOLD_W-1:0]   hold_reload;

    t_out_beat   predicted_beats [$];
    t_out_beat   oldest_beat;
    int unsigned beats_offered = 0;
    int          fail_count = 0;
    int          quiet = 0;
    int          tick_pct = 20;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          rx_long_hold = 1'b0;

    always #5 clk = ~clk;

    pulse_width_card_reader_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    task automatic reader_reset();
        for (int i = 0; i < MEMBER_CNT; i++) member_no[i] = MEMBER_RESET[i];
        for (int i = 0; i < 32; i++) frame_store[i] = 1'b0;
        hold_reload = LED_HOLD_RESET;
        skip_left = SKIP_AT_RESET;
        want_rise = 1'b0;
        stamp_only = 1'b1;
        fall_ts = '0;
        rise_ts = '0;
        low_span = '0;
        bit_idx = '0;
        led_on = 1'b0;
        hold_left = LED_HOLD_RESET;
        cards_ok = '0;
        last_card = '0;
    endtask

    function automatic int unsigned frame_digit(int unsigned pos);
        return {frame_store[pos], frame_store[pos+1], frame_store[pos+2], frame_store[pos+3]};
    endfunction

    function automatic t_out_beat reader_predict(t_in_beat ev);
        t_out_beat          r;
        logic [STAMP_W-1:0] hi;
        int unsigned        high_w;
        int unsigned        low_w;
        int unsigned        idx;
        int unsigned        num;
        logic               done;
        logic               matched;
        done = 1'b0;
        matched = 1'b0;
        if (ev.action == ACT_TICK) begin
            if (led_on) begin
                hold_left = hold_left - 1'b1;
                if (hold_left == 0) begin
                    led_on = 1'b0;
                    hold_left = hold_reload;
                end
            end
        end else if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
        end else if (want_rise) begin
            rise_ts = ev.capture_time;
            want_rise = 1'b0;
            stamp_only = 1'b0;
            low_span = rise_ts - fall_ts;
        end else begin
            fall_ts = ev.capture_time;
            if (!stamp_only) begin
                hi = fall_ts - rise_ts;
                high_w = hi;
                low_w = low_span;
                idx = bit_idx;
                if (21 * high_w > 10 * low_w) begin
                    frame_store[idx % 32] = 1'b1;
                end else if (low_w > 8 * high_w) begin
                    idx = 0;
                end else begin
                    frame_store[idx % 32] = 1'b0;
                end
                idx++;
                if (idx >= FRAME_BITS_DEF) begin
                    num = frame_digit(8) * 100 + frame_digit(12) * 10 + frame_digit(16);
                    stamp_only = 1'b1;
                    idx = 0;
                    skip_left = SKIP_AFTER_CARD;
                    last_card = num[NUM_W-1:0];
                    for (int i = 0; i < MEMBER_CNT; i++) begin
                        if (num == member_no[i]) matched = 1'b1;
                    end
                    if (matched) begin
                        led_on = 1'b1;
                        cards_ok = cards_ok + 1'b1;
                    end
                    done = 1'b1;
                end
                bit_idx = idx[4:0];
            end
            want_rise = 1'b1;
        end
        r.led_lit = led_on;
        r.person_count = cards_ok;
        r.card_done = done;
        r.card_accepted = matched;
        r.card_number = last_card;
        return r;
    endfunction

    task automatic offer(input t_in_beat b, input logic typed, input t_out_beat want);
        t_out_beat guess;
        if (!tx_calm && $urandom_range(4, 0) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge clk); while (!in_ready);
        guess = reader_predict(b);
        predicted_beats.push_back(typed ? want : guess);
        beats_offered++;
    endtask

    task automatic send_tick();
        offer('{action: ACT_TICK, capture_time: 16'($urandom)}, 1'b0, QUIET_RESULT);
    endtask

    task automatic send_edge(input logic [STAMP_W-1:0] t);
        if ($urandom_range(99, 0) < tick_pct) send_tick();
        offer('{action: ACT_EDGE, capture_time: t}, 1'b0, QUIET_RESULT);
    endtask

    // low time comes first (rise), then high time (fall)
    task automatic send_pair(input int unsigned low_t, input int unsigned high_t);
        send_edge(fall_ts + low_t[STAMP_W-1:0]);
        send_edge(rise_ts + high_t[STAMP_W-1:0]);
    endtask

    task automatic send_bit(input bit v);
        int unsigned h;
        int unsigned l;
        h = ($urandom_range(15, 0) == 0) ? $urandom_range(7000, 301) : $urandom_range(300, 1);
        if (v) l = $urandom_range((21 * h - 1) / 10, 0);
        else l = $urandom_range(8 * h, (21 * h + 9) / 10);
        send_pair(l, h);
    endtask

    task automatic send_frame(input bit clean);
        bit          card [1:FRAME_BITS_DEF-1];
        logic [3:0]  digits [3];
        int unsigned pick;
        int unsigned num;
        int unsigned stop_at;
        int unsigned h;
        int unsigned l;
        bit          with_sync;
        pick = clean ? 0 : $urandom_range(9, 0);
        if (pick <= 4) begin
            num = member_no[$urandom_range(MEMBER_CNT - 1, 0)];
            digits[0] = 4'(num / 100);
            digits[1] = 4'((num / 10) % 10);
            digits[2] = 4'(num % 10);
        end else begin
            for (int d = 0; d < 3; d++) begin
                if (pick <= 7) digits[d] = 4'($urandom_range(15, 0));
                else digits[d] = (pick == 8) ? 4'hF : 4'h0;
            end
        end
        for (int i = 1; i < FRAME_BITS_DEF; i++) card[i] = 1'($urandom_range(1, 0));
        for (int d = 0; d < 3; d++) begin
            for (int b = 0; b < 4; b++) card[8 + 4 * d + b] = digits[d][3 - b];
        end
        with_sync = clean || ($urandom_range(7, 0) != 0);
        stop_at = (!clean && $urandom_range(9, 0) == 0) ?
                  $urandom_range(FRAME_BITS_DEF - 1, 1) : FRAME_BITS_DEF;
        while (skip_left != 0 || !want_rise) send_edge(16'($urandom));
        if (with_sync) begin
            h = ($urandom_range(7, 0) == 0) ? $urandom_range(8000, 301) : $urandom_range(300, 1);
            l = $urandom_range((8 * h + 4000 > 65535) ? 65535 : 8 * h + 4000, 8 * h + 1);
            send_pair(l, h);
        end
        for (int i = 1; i < FRAME_BITS_DEF && i < stop_at; i++) begin
            if (!clean && $urandom_range(59, 0) == 0) send_edge(16'($urandom));
            send_bit(card[i]);
        end
    endtask

    task automatic hold_off_input();
        in_valid <= 1'b0;
        while (predicted_beats.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= CFG_MEMBER_F) member_no[idx] = val;
        else if (idx == CFG_LED_HOLD) hold_reload = val[HOLD_W-1:0];
    endtask

    task automatic load_settings(input int ph);
        case (ph)
            1: begin
                write_reg(CFG_MEMBER_A, 10'd0);
                write_reg(CFG_MEMBER_B, 10'd999);
                write_reg(CFG_MEMBER_C, 10'($urandom_range(999, 0)));
                write_reg(CFG_MEMBER_D, 10'($urandom_range(999, 0)));
                write_reg(CFG_MEMBER_E, 10'($urandom_range(999, 0)));
                write_reg(CFG_MEMBER_F, 10'($urandom_range(999, 0)));
                write_reg(CFG_LED_HOLD, 10'd1);
            end
            2: begin
                write_reg(CFG_MEMBER_C, 10'($urandom_range(999, 0)));
                write_reg(CFG_MEMBER_D, 10'($urandom_range(999, 0)));
                write_reg(CFG_LED_HOLD, 10'd255);
            end
            ZERO_HOLD_PHASE: begin
                write_reg(CFG_LED_HOLD, 10'd0);
            end
            default: begin
                write_reg(CFG_UNUSED, 10'($urandom_range(1023, 0)));
                write_reg(CFG_MEMBER_F, 10'($urandom_range(999, 0)));
                write_reg(CFG_LED_HOLD, 10'($urandom_range(254, 1)));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int ph);
        int unsigned first_beat;
        int          frame_no;
        bit          long_hold_done;
        first_beat = beats_offered;
        frame_no = 0;
        long_hold_done = 1'b0;
        tick_pct = (ph == ZERO_HOLD_PHASE) ? 35 : 20;
        while (beats_offered - first_beat < PHASE_BEATS ||
               (ph == ZERO_HOLD_PHASE && frame_no < 2)) begin
            tx_calm = (ph == LAST_PHASE) || ($urandom_range(3, 0) == 0);
            rx_calm = (ph == LAST_PHASE) || ($urandom_range(3, 0) == 0);
            if (ph == 1 && !long_hold_done && beats_offered - first_beat > 100) begin
                rx_long_hold = 1'b1;
                tx_calm = 1'b1;
                long_hold_done = 1'b1;
            end
            if (ph == ZERO_HOLD_PHASE && frame_no < 2) begin
                // light the led, then tick it all the way down
                send_frame(1'b1);
                repeat (TICK_BURST) send_tick();
            end else begin
                if ($urandom_range(2, 0) == 0) begin
                    repeat ($urandom_range(6, 1)) begin
                        offer('{action: 1'($urandom_range(1, 0)), capture_time: 16'($urandom)},
                              1'b0, QUIET_RESULT);
                    end
                end
                send_frame(1'b0);
            end
            frame_no++;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (predicted_beats.size() == 0) begin
                $display("%0t: result beat with none awaited, expected none got %h",
                         $time, out_beat);
                fail_count++;
            end else begin
                oldest_beat = predicted_beats.pop_front();
                check_field("led_lit", oldest_beat.led_lit, out_beat.led_lit);
                check_field("person_count", oldest_beat.person_count, out_beat.person_count);
                check_field("card_done", oldest_beat.card_done, out_beat.card_done);
                check_field("card_accepted", oldest_beat.card_accepted, out_beat.card_accepted);
                check_field("card_number", oldest_beat.card_number, out_beat.card_number);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("tb_pulse_width_card_reader_unit: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_long_hold) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_long_hold = 1'b0;
            end else if (!rx_calm && $urandom_range(2, 0) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(30, 1)) @(posedge clk);
            end
        end
    end

    initial begin
        reader_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIR_ROWS[i]) offer(DIR_ROWS[i].beat, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        for (int ph = 0; ph <= LAST_PHASE; ph++) begin
            if (ph > 0) begin
                hold_off_input();
                load_settings(ph);
            end
            run_phase(ph);
        end
        hold_off_input();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_pulse_width_card_reader_unit: PASS");
        end else begin
            $display("tb_pulse_width_card_reader_unit: FAIL");
        end
        $finish;
    end

endmodule
